>>> rtl/core/fcbh_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the four-choice bucket hash table
package fcbh_pkg;

  localparam int TABLE_ROWS_DEF     = 1024;
  localparam int CELLS_PER_ROW_DEF  = 7;
  localparam int EXTENSION_ROWS_DEF = 64;

  localparam int COUNT_W = 13;
  localparam int WORD_W  = 32;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b00000000001,
    S_IDLE     = 11'b00000000010,
    S_CHOICE   = 11'b00000000100,
    S_ROW_WAIT = 11'b00000001000,
    S_CELL     = 11'b00000010000,
    S_CMP      = 11'b00000100000,
    S_LINK     = 11'b00001000000,
    S_RESOLVE  = 11'b00010000000,
    S_TAIL_RD  = 11'b00100000000,
    S_TAIL_WR  = 11'b01000000000,
    S_FINISH   = 11'b10000000000
  } fsm_t;

endpackage

>>> rtl/core/four_choice_bucket_hash_table.sv
`timescale 1ns / 1ps
// four-choice bucket hash table: add, find and remove over rows with overflow chains
// steps: choice slots are walked level by level down the chains and each live row is read;
//   an add takes the lowest free cell or passes a full row, find/remove compare each valid
//   cell's key; resolve, tail read/write for a new pool row, finish; OP_NONE goes to finish
// throughput: one item at a time, the next taken the cycle after the result is registered
// reset: a clearing pass over all TABLE_ROWS+EXTENSION_ROWS rows (1088 by default) empties all
//   row masks and links; no item is taken until it ends
module four_choice_bucket_hash_table #(
  parameter int TABLE_ROWS     = fcbh_pkg::TABLE_ROWS_DEF,
  parameter int CELLS_PER_ROW  = fcbh_pkg::CELLS_PER_ROW_DEF,
  parameter int EXTENSION_ROWS = fcbh_pkg::EXTENSION_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [fcbh_pkg::WORD_W-1:0] hash_word_a,
  input  logic [fcbh_pkg::WORD_W-1:0] hash_word_b,
  input  logic [fcbh_pkg::WORD_W-1:0] hash_word_c,
  input  logic [fcbh_pkg::WORD_W-1:0] hash_word_d,
  input  logic [fcbh_pkg::WORD_W-1:0] key_tag,
  input  logic [fcbh_pkg::WORD_W-1:0] object_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [fcbh_pkg::WORD_W-1:0] found_value,
  output logic                        used_extension,
  output logic [fcbh_pkg::COUNT_W-1:0] entry_total
);

  localparam int ALL_ROWS  = TABLE_ROWS + EXTENSION_ROWS;
  localparam int ALL_CELLS = ALL_ROWS * CELLS_PER_ROW;
  localparam int TW        = $clog2(TABLE_ROWS);
  localparam int ROW_W     = $clog2(ALL_ROWS);
  localparam int CELL_W    = $clog2(ALL_CELLS);
  localparam int LINK_W    = $clog2(EXTENSION_ROWS + 1);
  localparam int CW        = $clog2(CELLS_PER_ROW + 1);
  localparam int IDXW      = (CELLS_PER_ROW > 1) ? $clog2(CELLS_PER_ROW) : 1;
  localparam int GW        = $clog2(EXTENSION_ROWS + 2);
  localparam int WW        = fcbh_pkg::WORD_W;
  localparam int NW        = fcbh_pkg::COUNT_W;

  // memories: per-row valid mask and link, per-cell key and object
  logic [CELLS_PER_ROW-1:0] row_mask [ALL_ROWS];
  logic [LINK_W-1:0]        row_link [ALL_ROWS];
  logic [WW-1:0]            cell_key [ALL_CELLS];
  logic [WW-1:0]            cell_obj [ALL_CELLS];

  fcbh_pkg::fsm_t state, state_next;

  logic [ROW_W-1:0]         clr_cnt;
  logic [1:0]               op;
  logic [WW-1:0]            key;
  logic [WW-1:0]            obj;
  logic [ROW_W-1:0]         cur_row [4];
  logic [3:0]               live;
  logic [2:0]               choice;
  logic [CW-1:0]            cell_pos;
  logic                     more;
  logic [GW-1:0]            guard;
  logic                     found;
  logic [ROW_W-1:0]         found_row;
  logic [CW-1:0]            found_cell;
  logic                     extend;
  logic [ROW_W-1:0]         tail_row;
  logic [LINK_W-1:0]        pool_used;
  logic [NW-1:0]            entry_count;
  logic [CELLS_PER_ROW-1:0] mask_q;
  logic [LINK_W-1:0]        link_q;

  // result held until the output register is free
  logic [1:0]               res_status;
  logic [WW-1:0]            res_value;
  logic                     res_ext;

  // memory read data, registered
  logic [CELLS_PER_ROW-1:0] rd_mask;
  logic [LINK_W-1:0]        rd_link;
  logic [WW-1:0]            rd_key;
  logic [WW-1:0]            rd_obj;

  // memory port controls
  logic [ROW_W-1:0]         row_ra;
  logic                     row_we;
  logic [ROW_W-1:0]         row_wa;
  logic [CELLS_PER_ROW-1:0] row_wmask;
  logic [LINK_W-1:0]        row_wlink;
  logic [CELL_W-1:0]        cell_ra;
  logic                     cell_we;
  logic [CELL_W-1:0]        cell_wa;

  logic [ROW_W-1:0]         cur_sel;
  logic [ROW_W-1:0]         new_row;
  logic [CELL_W-1:0]        found_idx;
  logic [CELLS_PER_ROW-1:0] found_bit;
  logic                     out_free;
  logic                     rd_full;
  logic [CW-1:0]            first_free;
  logic [ROW_W-1:0]         in_row [4];
  logic [3:0]               in_live;
  logic [GW-1:0]            guard_inc;
  logic                     link_ok;

  assign cur_sel   = cur_row[choice[1:0]];
  assign new_row   = ROW_W'(TABLE_ROWS) + ROW_W'(pool_used);
  assign found_idx = CELL_W'(found_row) * CELL_W'(CELLS_PER_ROW) + CELL_W'(found_cell);
  assign found_bit = CELLS_PER_ROW'(1) << found_cell;
  assign out_free  = !out_valid || !out_stall;
  assign rd_full   = (rd_mask == {CELLS_PER_ROW{1'b1}});
  assign guard_inc = guard + GW'(1);
  assign link_ok   = (link_q != '0) && (link_q <= LINK_W'(EXTENSION_ROWS));
  assign in_stall  = (state != fcbh_pkg::S_IDLE);

  // lowest free cell of the row just read
  always_comb begin
    first_free = '0;
    for (int k = CELLS_PER_ROW - 1; k >= 0; k--) begin
      if (!rd_mask[k]) first_free = CW'(k);
    end
  end

  // row choices from the hash words; a repeated row is dropped
  always_comb begin
    in_row[0] = ROW_W'(hash_word_a[TW-1:0]);
    in_row[1] = ROW_W'(hash_word_b[TW-1:0]);
    in_row[2] = ROW_W'(hash_word_c[TW-1:0]);
    in_row[3] = ROW_W'(hash_word_d[TW-1:0]);
    in_live   = 4'b1111;
    for (int i = 1; i < 4; i++) begin
      for (int o = 0; o < i; o++) begin
        if (in_row[o] == in_row[i]) in_live[i] = 1'b0;
      end
    end
  end

  // memory port addressing
  always_comb begin
    row_ra    = (state == fcbh_pkg::S_TAIL_RD) ? tail_row : cur_sel;
    cell_ra   = CELL_W'(cur_sel) * CELL_W'(CELLS_PER_ROW) + CELL_W'(cell_pos);
    row_we    = 1'b0;
    row_wa    = found_row;
    row_wmask = mask_q;
    row_wlink = link_q;
    cell_we   = 1'b0;
    cell_wa   = found_idx;
    case (state)
      fcbh_pkg::S_CLEAR: begin
        row_we    = 1'b1;
        row_wa    = clr_cnt;
        row_wmask = '0;
        row_wlink = '0;
      end
      fcbh_pkg::S_RESOLVE: begin
        if (found) begin
          if (op == fcbh_pkg::OP_ADD) begin
            row_we    = 1'b1;
            row_wmask = mask_q | found_bit;
            cell_we   = 1'b1;
          end else if (op == fcbh_pkg::OP_REMOVE) begin
            row_we    = 1'b1;
            row_wmask = mask_q & ~found_bit;
          end
        end else if (op == fcbh_pkg::OP_ADD && extend &&
                     pool_used < LINK_W'(EXTENSION_ROWS)) begin
          // fresh pool row: entry in cell 0, no onward link
          row_we    = 1'b1;
          row_wa    = new_row;
          row_wmask = CELLS_PER_ROW'(1);
          row_wlink = '0;
          cell_we   = 1'b1;
          cell_wa   = CELL_W'(new_row) * CELL_W'(CELLS_PER_ROW);
        end
      end
      fcbh_pkg::S_TAIL_WR: begin
        row_we    = 1'b1;
        row_wa    = tail_row;
        row_wmask = rd_mask;
        row_wlink = pool_used + LINK_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mask[row_wa] <= row_wmask;
      row_link[row_wa] <= row_wlink;
    end
    rd_mask <= row_mask[row_ra];
    rd_link <= row_link[row_ra];
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_key[cell_wa] <= key;
      cell_obj[cell_wa] <= obj;
    end
    rd_key <= cell_key[cell_ra];
    rd_obj <= cell_obj[cell_ra];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      fcbh_pkg::S_CLEAR:
        if (clr_cnt == ROW_W'(ALL_ROWS - 1)) state_next = fcbh_pkg::S_IDLE;
      fcbh_pkg::S_IDLE:
        if (in_valid) begin
          state_next = (operation == fcbh_pkg::OP_NONE) ? fcbh_pkg::S_FINISH
                                                          : fcbh_pkg::S_CHOICE;
        end
      fcbh_pkg::S_CHOICE:
        if (choice == 3'd4) begin
          state_next = (more && guard_inc <= GW'(EXTENSION_ROWS))
                       ? fcbh_pkg::S_CHOICE : fcbh_pkg::S_RESOLVE;
        end else if (live[choice[1:0]]) begin
          state_next = fcbh_pkg::S_ROW_WAIT;
        end
      fcbh_pkg::S_ROW_WAIT:
        if (op == fcbh_pkg::OP_ADD) begin
          state_next = rd_full ? fcbh_pkg::S_LINK : fcbh_pkg::S_RESOLVE;
        end else begin
          state_next = fcbh_pkg::S_CELL;
        end
      fcbh_pkg::S_CELL:
        if (cell_pos == CW'(CELLS_PER_ROW)) state_next = fcbh_pkg::S_LINK;
        else if (mask_q[cell_pos[IDXW-1:0]]) state_next = fcbh_pkg::S_CMP;
      fcbh_pkg::S_CMP:
        state_next = (rd_key == key) ? fcbh_pkg::S_RESOLVE : fcbh_pkg::S_CELL;
      fcbh_pkg::S_LINK:
        state_next = fcbh_pkg::S_CHOICE;
      fcbh_pkg::S_RESOLVE:
        if (!found && op == fcbh_pkg::OP_ADD && extend &&
            pool_used < LINK_W'(EXTENSION_ROWS)) begin
          state_next = fcbh_pkg::S_TAIL_RD;
        end else begin
          state_next = fcbh_pkg::S_FINISH;
        end
      fcbh_pkg::S_TAIL_RD:
        state_next = fcbh_pkg::S_TAIL_WR;
      fcbh_pkg::S_TAIL_WR:
        state_next = fcbh_pkg::S_FINISH;
      fcbh_pkg::S_FINISH:
        if (out_free) state_next = fcbh_pkg::S_IDLE;
      default:
        state_next = fcbh_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fcbh_pkg::S_CLEAR;
      clr_cnt     <= '0;
      pool_used   <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      // finish loads a new result itself
      if (out_valid && !out_stall && state != fcbh_pkg::S_FINISH) out_valid <= 1'b0;
      case (state)
        fcbh_pkg::S_CLEAR:
          clr_cnt <= clr_cnt + ROW_W'(1);
        fcbh_pkg::S_IDLE:
          if (in_valid) begin
            op         <= operation;
            key        <= key_tag;
            obj        <= object_value;
            for (int i = 0; i < 4; i++) cur_row[i] <= in_row[i];
            live       <= in_live;
            choice     <= '0;
            more       <= 1'b0;
            guard      <= '0;
            found      <= 1'b0;
            extend     <= 1'b0;
            res_status <= fcbh_pkg::ST_NOTFOUND;
            res_value  <= '0;
            res_ext    <= 1'b0;
          end
        fcbh_pkg::S_CHOICE:
          if (choice == 3'd4) begin
            // end of a level: next level of the chains
            guard  <= guard_inc;
            choice <= '0;
            more   <= 1'b0;
          end else if (!live[choice[1:0]]) begin
            choice <= choice + 3'd1;
          end
        fcbh_pkg::S_ROW_WAIT: begin
          mask_q    <= rd_mask;
          link_q    <= rd_link;
          found_row <= cur_sel;
          cell_pos  <= '0;
          if (op == fcbh_pkg::OP_ADD && !rd_full) begin
            found      <= 1'b1;
            found_cell <= first_free;
          end
        end
        fcbh_pkg::S_CELL:
          if (cell_pos != CW'(CELLS_PER_ROW) && !mask_q[cell_pos[IDXW-1:0]]) begin
            cell_pos <= cell_pos + CW'(1);
          end
        fcbh_pkg::S_CMP:
          if (rd_key == key) begin
            found      <= 1'b1;
            found_cell <= cell_pos;
            res_value  <= rd_obj;
          end else begin
            cell_pos <= cell_pos + CW'(1);
          end
        fcbh_pkg::S_LINK: begin
          if (link_ok) begin
            cur_row[choice[1:0]] <= ROW_W'(TABLE_ROWS) + ROW_W'(link_q) - ROW_W'(1);
            more <= 1'b1;
          end else begin
            live[choice[1:0]] <= 1'b0;
            if (!extend) begin
              extend   <= 1'b1;
              tail_row <= cur_sel;
            end
          end
          choice <= choice + 3'd1;
        end
        fcbh_pkg::S_RESOLVE:
          if (found) begin
            res_status <= fcbh_pkg::ST_OK;
            if (op == fcbh_pkg::OP_ADD) begin
              res_value   <= obj;
              entry_count <= entry_count + NW'(1);
            end else if (op == fcbh_pkg::OP_REMOVE && entry_count != '0) begin
              entry_count <= entry_count - NW'(1);
            end
          end else if (op == fcbh_pkg::OP_ADD) begin
            if (extend && pool_used < LINK_W'(EXTENSION_ROWS)) begin
              res_status  <= fcbh_pkg::ST_OK;
              res_value   <= obj;
              res_ext     <= 1'b1;
              entry_count <= entry_count + NW'(1);
            end else begin
              res_status <= fcbh_pkg::ST_FULL;
            end
          end
        fcbh_pkg::S_TAIL_WR:
          pool_used <= pool_used + LINK_W'(1);
        fcbh_pkg::S_FINISH:
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            found_value    <= res_value;
            used_extension <= res_ext;
            entry_total    <= entry_count;
          end
        default: ;
      endcase
    end
  end

endmodule
